[hdl/lumi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lumi_pkg: shared types and constants for the LU matrix inverse block
// Register indexes and the job record passed from loader to solver.
// ----------------------------------------------------------------------------
package lumi_pkg;
   localparam logic [3:0] REG_MATRIX_SIZE     = 4'd0;
   localparam logic [3:0] REG_PIVOT_THRESHOLD = 4'd1;
   localparam int         CSR_ADDR_BITS       = 4;

   typedef struct packed {
      logic [4:0]  order;
      logic [15:0] threshold;
   } job_type;
endpackage
`default_nettype wire

[hdl/lu_matrix_inverse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lu_matrix_inverse: fixed-point matrix inverse by LU factorization
// Loads an n x n matrix, factors it and returns its inverse row by row, or one
// result flagged singular.
// Elements are taken one per cycle while busy is low. Busy rises the cycle after
// the last element of a matrix and stays high until the solver has finished the
// factorization and substitutions on that matrix; the next matrix may load while
// the inverse streams out. The solver performs one multiply or one divide at a
// time (the shared bit-serial divider sets the pace), then streams the n*n
// results of the inverse, or a single singular result. Results carry a one-cycle
// strobe and cannot be stalled.
module lu_matrix_inverse #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire signed [31:0]  req_element,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [lumi_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  wire  [31:0]        csr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_inverse_value,
   output logic               rsp_singular,
   output logic               rsp_last
);
   localparam int AW = $clog2(MAX_ORDER*MAX_ORDER);
   logic [15:0] thr_ff;
   logic [AW-1:0] wr_addr;
   logic job_valid, job_pop, full, accept, csr_wr, solving;
   lumi_pkg::job_type job;

   // hold input while a job waits or the solver still reads the stored matrix
   assign busy      = full || job_valid || solving;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 16'd1;
      else if (csr_wr && csr_index == lumi_pkg::REG_PIVOT_THRESHOLD) thr_ff <= csr_data[15:0];
   end

   lumi_loader #(.MAX_ORDER(MAX_ORDER)) u_loader (
      .clock(clock), .reset(reset), .accept(accept),
      .size_write(csr_wr && csr_index == lumi_pkg::REG_MATRIX_SIZE),
      .size_value(csr_data[3:0]), .threshold(thr_ff), .wr_addr(wr_addr),
      .job_valid(job_valid), .job(job), .job_pop(job_pop), .queue_full(full));

   lumi_solver #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_solver (
      .clock(clock), .reset(reset), .wr_en(accept), .wr_addr(wr_addr),
      .wr_data(req_element), .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .solving(solving),
      .rsp_valid(rsp_valid), .rsp_inverse_value(rsp_inverse_value),
      .rsp_singular(rsp_singular), .rsp_last(rsp_last));
endmodule
`default_nettype wire

[hdl/lumi_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lumi_divider: iterative fixed-point divider
// Computes sat32((a << FRAC_BITS) / b) truncated toward zero, one quotient bit
// per cycle. A zero divisor gives the extreme value by the sign of a.
// ----------------------------------------------------------------------------
module lumi_divider #(
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire signed [31:0]  num,
   input  wire signed [31:0]  den,
   output logic               done,
   output logic signed [31:0] quo
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] rem_ff, q_ff;
   logic [31:0]   d_ff;
   logic          neg_ff, zero_ff, busy_ff, sa_ff, nz_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW:0]   trial;
   logic [NW-1:0] na;
   logic [NW:0]   qs;

   assign na    = num[31] ? NW'(-{{FRAC_BITS{num[31]}}, num})
                          : NW'({{FRAC_BITS{1'b0}}, num});
   assign trial = {rem_ff, q_ff[NW-1]} - {{(NW-31){1'b0}}, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
            rem_ff  <= '0;
            q_ff    <= na << FRAC_BITS;
            d_ff    <= den[31] ? 32'(-den) : den;
            neg_ff  <= num[31] ^ den[31];
            sa_ff   <= num[31];
            nz_ff   <= (num != 32'sd0);
            zero_ff <= (den == 32'sd0);
         end else if (busy_ff) begin
            if (!trial[NW]) begin
               rem_ff <= trial[NW-1:0];
               q_ff   <= {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[NW-2:0], q_ff[NW-1]};
               q_ff   <= {q_ff[NW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   // q_ff holds the magnitude once done; zero over zero gives zero
   always_comb begin
      qs = neg_ff ? -{1'b0, q_ff} : {1'b0, q_ff};
      if (zero_ff) begin
         if (!nz_ff) quo = 32'sd0;
         else quo = sa_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (!neg_ff && q_ff > NW'(32'h7fff_ffff)) quo = 32'sh7fff_ffff;
      else if (neg_ff && q_ff > NW'(33'h8000_0000)) quo = 32'sh8000_0000;
      else quo = qs[31:0];
   end
endmodule
`default_nettype wire

[hdl/lumi_loader.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lumi_loader: front end
// Counts incoming elements, passes each with its address to the solver and
// posts a job into a short queue when the last element of a matrix arrives.
// ----------------------------------------------------------------------------
module lumi_loader #(
   parameter int MAX_ORDER = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  wire                  size_write,
   input  wire  [3:0]           size_value,
   input  wire  [15:0]          threshold,
   output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] wr_addr,
   output logic                 job_valid,
   output lumi_pkg::job_type    job,
   input  wire                  job_pop,
   output logic                 queue_full
);
   localparam int AW = $clog2(MAX_ORDER*MAX_ORDER);
   logic [3:0]  size_ff;
   logic [AW:0] count_ff;
   logic [4:0]  order;
   logic [9:0]  total;
   lumi_pkg::job_type q_ff [2];
   logic [1:0]  fill_ff;
   logic        push;

   always_comb begin
      order = 5'(size_ff);
      if (size_ff == 4'd0) order = 5'd1;
      if (32'(size_ff) > MAX_ORDER) order = 5'(MAX_ORDER);
      total = 10'(order) * 10'(order);
   end
   assign wr_addr    = count_ff[AW-1:0];
   assign push       = accept && (10'(count_ff) + 10'd1 == total);
   assign job_valid  = fill_ff != 2'd0;
   assign job        = q_ff[0];
   assign queue_full = fill_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 4'd8;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         if (size_write) begin
            size_ff  <= size_value;
            count_ff <= '0;
         end else if (accept) count_ff <= push ? '0 : count_ff + 1'b1;
         // the new job lands in the first free slot after any pop
         if (push && (job_pop ? fill_ff == 2'd1 : fill_ff == 2'd0))
            q_ff[0] <= '{order, threshold};
         else if (job_pop) q_ff[0] <= q_ff[1];
         if (push && (job_pop ? fill_ff == 2'd2 : fill_ff == 2'd1))
            q_ff[1] <= '{order, threshold};
         fill_ff <= fill_ff + 2'(push) - 2'(job_pop);
      end
   end
endmodule
`default_nettype wire

[hdl/lumi_solver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lumi_solver: back end
// Runs the in-place LU factorization and substitutions on the stored matrix,
// one multiply or one divide at a time, then streams out the inverse.
// ----------------------------------------------------------------------------
module lumi_solver #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_en,
   input  wire  [$clog2(MAX_ORDER*MAX_ORDER)-1:0] wr_addr,
   input  wire  signed [31:0]   wr_data,
   input  wire                  job_valid,
   input  lumi_pkg::job_type    job,
   output logic                 job_pop,
   output logic                 solving,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_inverse_value,
   output logic                 rsp_singular,
   output logic                 rsp_last
);
   localparam int AW = $clog2(MAX_ORDER*MAX_ORDER);
   localparam int IW = $clog2(MAX_ORDER) + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_PIV_RD, S_PIV_CHK, S_DIV_RD, S_UPD_LD, S_DIV_WT,
      S_UPD_RD, S_UPD_MUL, S_UPD_WR,
      S_INIT, S_FW_RD, S_FW_MUL, S_FW_ACC, S_FW_WR,
      S_BK_RD, S_BK_MUL, S_BK_ACC, S_BK_DIV, S_BK_WT,
      S_OUT_RD, S_OUT
   } state_type;

   logic signed [31:0] mstore [MAX_ORDER*MAX_ORDER];
   logic signed [31:0] istore [MAX_ORDER*MAX_ORDER];
   state_type state_ff;
   logic [IW-1:0] n_ff, k_ff, i_ff, j_ff, c_ff;
   logic [15:0]   thr_ff;
   logic signed [31:0] a_ff, b_ff, x_ff, piv_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic [AW:0]   oidx_ff;
   logic signed [31:0] mul_r;
   logic signed [63:0] pr;
   logic signed [32:0] dsub;
   logic          div_start, div_done;
   logic signed [31:0] div_num, div_den, div_quo;
   logic [32:0]   pmag;

   function automatic logic [AW-1:0] ad(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                        input logic [IW-1:0] n);
      ad = AW'(32'(r) * 32'(n) + 32'(c));
   endfunction
   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat = 32'sh7fff_ffff;
      else if (v < -64'sd2147483648) sat = 32'sh8000_0000;
      else sat = v[31:0];
   endfunction

   // round half up then saturate the registered product
   assign pr    = (prod_ff + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
   assign mul_r = sat(pr);
   assign dsub  = {a_ff[31], a_ff} - {mul_r[31], mul_r};
   assign pmag  = piv_ff[31] ? 33'(-{piv_ff[31], piv_ff}) : {1'b0, piv_ff};
   // the matrix store is in use from the pop until the last substitution
   assign solving = !(state_ff inside {S_IDLE, S_OUT_RD, S_OUT});

   lumi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quo(div_quo));

   always_ff @(posedge clock) begin
      if (wr_en) mstore[wr_addr] <= wr_data;
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         job_pop   <= 1'b0;
         div_start <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         job_pop   <= 1'b0;
         div_start <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (job_valid && !job_pop) begin
               job_pop  <= 1'b1;
               n_ff     <= IW'(job.order);
               thr_ff   <= job.threshold;
               k_ff     <= '0;
               state_ff <= S_PIV_RD;
            end
            S_PIV_RD: begin
               piv_ff <= mstore[ad(k_ff, k_ff, n_ff)];
               i_ff   <= k_ff + 1'b1;
               state_ff <= S_PIV_CHK;
            end
            S_PIV_CHK:
               if (pmag < {17'd0, thr_ff}) begin
                  rsp_valid <= 1'b1;
                  rsp_inverse_value <= '0;
                  rsp_singular <= 1'b1;
                  rsp_last <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (k_ff + 1'b1 == n_ff) begin
                  c_ff <= '0;
                  i_ff <= '0;
                  state_ff <= S_INIT;
               end else state_ff <= S_DIV_RD;
            S_DIV_RD: begin
               div_num <= mstore[ad(i_ff, k_ff, n_ff)];
               div_den <= piv_ff;
               div_start <= 1'b1;
               state_ff <= S_DIV_WT;
            end
            S_DIV_WT: if (div_done) begin
               mstore[ad(i_ff, k_ff, n_ff)] <= div_quo;
               if (i_ff + 1'b1 == n_ff) begin
                  i_ff <= k_ff + 1'b1;
                  j_ff <= k_ff + 1'b1;
                  state_ff <= S_UPD_LD;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_DIV_RD;
               end
            end
            // fetch the row multiplier once per row
            S_UPD_LD: begin
               b_ff <= mstore[ad(i_ff, k_ff, n_ff)];
               state_ff <= S_UPD_RD;
            end
            S_UPD_RD: begin
               a_ff <= mstore[ad(i_ff, j_ff, n_ff)];
               x_ff <= mstore[ad(k_ff, j_ff, n_ff)];
               state_ff <= S_UPD_MUL;
            end
            S_UPD_MUL: begin
               prod_ff <= 64'(b_ff) * 64'(x_ff);
               state_ff <= S_UPD_WR;
            end
            S_UPD_WR: begin
               mstore[ad(i_ff, j_ff, n_ff)] <= sat(64'(dsub));
               if (j_ff + 1'b1 != n_ff) begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_UPD_RD;
               end else if (i_ff + 1'b1 != n_ff) begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= k_ff + 1'b1;
                  state_ff <= S_UPD_LD;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  state_ff <= S_PIV_RD;
               end
            end
            S_INIT: begin
               istore[ad(i_ff, c_ff, n_ff)] <= (i_ff == c_ff) ?
                  32'(64'sd1 <<< FRAC_BITS) : 32'sd0;
               if (i_ff + 1'b1 == n_ff) begin
                  acc_ff <= '0;
                  // a single row has no forward pass and nothing to add
                  if (n_ff == IW'(1)) begin
                     i_ff <= '0;
                     j_ff <= IW'(1);
                     state_ff <= S_BK_ACC;
                  end else begin
                     i_ff <= IW'(1);
                     j_ff <= '0;
                     state_ff <= S_FW_RD;
                  end
               end else i_ff <= i_ff + 1'b1;
            end
            S_FW_RD: begin
               b_ff <= mstore[ad(i_ff, j_ff, n_ff)];
               x_ff <= istore[ad(j_ff, c_ff, n_ff)];
               state_ff <= S_FW_MUL;
            end
            S_FW_MUL: begin
               prod_ff <= 64'(b_ff) * 64'(x_ff);
               state_ff <= S_FW_ACC;
            end
            S_FW_ACC: begin
               acc_ff <= acc_ff + 64'(mul_r);
               if (j_ff + 1'b1 == i_ff) begin
                  a_ff <= istore[ad(i_ff, c_ff, n_ff)];
                  state_ff <= S_FW_WR;
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_FW_RD;
               end
            end
            S_FW_WR: begin
               istore[ad(i_ff, c_ff, n_ff)] <= sat(64'(a_ff) - acc_ff);
               acc_ff <= '0;
               if (i_ff + 1'b1 == n_ff) begin
                  i_ff <= n_ff - 1'b1;
                  j_ff <= n_ff;
                  state_ff <= S_BK_ACC;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= '0;
                  state_ff <= S_FW_RD;
               end
            end
            S_BK_RD: begin
               b_ff <= mstore[ad(i_ff, j_ff, n_ff)];
               x_ff <= istore[ad(j_ff, c_ff, n_ff)];
               state_ff <= S_BK_MUL;
            end
            S_BK_MUL: begin
               prod_ff <= 64'(b_ff) * 64'(x_ff);
               j_ff <= j_ff + 1'b1;
               state_ff <= S_BK_ACC;
            end
            S_BK_ACC: begin
               // j_ff == n_ff on entry from forward pass: nothing to add yet
               if (state_ff == S_BK_ACC && j_ff != IW'(0) && j_ff > i_ff + 1'b1)
                  acc_ff <= acc_ff + 64'(mul_r);
               if (j_ff < n_ff) state_ff <= S_BK_RD;
               else begin
                  a_ff <= istore[ad(i_ff, c_ff, n_ff)];
                  piv_ff <= mstore[ad(i_ff, i_ff, n_ff)];
                  state_ff <= S_BK_DIV;
               end
            end
            S_BK_DIV: begin
               div_num <= sat(64'(a_ff) - acc_ff);
               div_den <= piv_ff;
               div_start <= 1'b1;
               state_ff <= S_BK_WT;
            end
            S_BK_WT: if (div_done) begin
               istore[ad(i_ff, c_ff, n_ff)] <= div_quo;
               acc_ff <= '0;
               if (i_ff != '0) begin
                  i_ff <= i_ff - 1'b1;
                  j_ff <= i_ff;
                  state_ff <= (i_ff == n_ff) ? S_BK_ACC : S_BK_ACC;
               end else if (c_ff + 1'b1 != n_ff) begin
                  c_ff <= c_ff + 1'b1;
                  i_ff <= '0;
                  state_ff <= S_INIT;
               end else begin
                  oidx_ff <= '0;
                  state_ff <= S_OUT_RD;
               end
            end
            S_OUT_RD: begin
               a_ff <= istore[oidx_ff[AW-1:0]];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_inverse_value <= a_ff;
               rsp_singular <= 1'b0;
               rsp_last <= 10'(oidx_ff) + 10'd1 == 10'(n_ff) * 10'(n_ff);
               if (10'(oidx_ff) + 10'd1 == 10'(n_ff) * 10'(n_ff)) state_ff <= S_IDLE;
               else begin
                  oidx_ff <= oidx_ff + 1'b1;
                  state_ff <= S_OUT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> rsp_last) else $error("singular not last");
   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> $past(state_ff == S_IDLE)) else $error("pop outside idle");
endmodule
`default_nettype wire

[sim/tb_lu_matrix_inverse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_lu_matrix_inverse: self-checking bench for the LU matrix inverse block
// Streams matrices through the block, predicts each inverse (or the singular
// flag) with a fixed-point LU solver of its own and compares every result.
// ----------------------------------------------------------------------------

class inverse_scoreboard;
   localparam int MAXN = 8;
   localparam int FB   = 16;

   logic signed [31:0] cells [64];
   logic signed [31:0] inv [64];
   int unsigned        loaded;
   logic [3:0]         size_reg;
   logic [15:0]        threshold_reg;

   logic signed [31:0] want_value [$];
   logic               want_singular [$];
   logic               want_last [$];
   int                 mismatches;

   function void clear();
      loaded        = 0;
      size_reg      = 4'd8;
      threshold_reg = 16'd1;
      mismatches    = 0;
      want_value.delete();
      want_singular.delete();
      want_last.delete();
   endfunction

   function void write_reg(logic [3:0] idx, logic [31:0] data);
      if (idx == lumi_pkg::REG_MATRIX_SIZE) begin
         size_reg = data[3:0];
         loaded   = 0;
      end else if (idx == lumi_pkg::REG_PIVOT_THRESHOLD) begin
         threshold_reg = data[15:0];
      end
   endfunction

   function int unsigned order_now();
      if (size_reg == 0) return 1;
      if (size_reg > MAXN) return MAXN;
      return size_reg;
   endfunction

   function logic signed [31:0] clip(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< (FB - 1));
      return clip(p >>> FB);
   endfunction

   function logic signed [31:0] qdiv(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] num;
      if (b == 0) begin
         if (a > 0) return 32'sh7fffffff;
         if (a < 0) return 32'sh80000000;
         return 0;
      end
      num = 64'(a) <<< FB;
      return clip(num / 64'(b));
   endfunction

   function bit factor(int n);
      logic signed [31:0] piv, pr;
      logic signed [63:0] mag;
      for (int k = 0; k < n; k++) begin
         piv = cells[k*n+k];
         mag = 64'(piv);
         if (mag < 0) mag = -mag;
         if (mag < 64'(threshold_reg)) return 0;
         for (int i = k + 1; i < n; i++) cells[i*n+k] = qdiv(cells[i*n+k], piv);
         for (int i = k + 1; i < n; i++)
            for (int j = k + 1; j < n; j++) begin
               pr = qmul(cells[i*n+k], cells[k*n+j]);
               cells[i*n+j] = clip(64'(cells[i*n+j]) - 64'(pr));
            end
      end
      return 1;
   endfunction

   function void solve_column(int n, int c);
      logic signed [63:0] s;
      for (int i = 0; i < n; i++) inv[i*n+c] = (i == c) ? 32'sh10000 : 0;
      for (int i = 1; i < n; i++) begin
         s = 0;
         for (int j = 0; j < i; j++) s += 64'(qmul(cells[i*n+j], inv[j*n+c]));
         inv[i*n+c] = clip(64'(inv[i*n+c]) - s);
      end
      for (int i = n - 1; i >= 0; i--) begin
         s = 0;
         for (int j = i + 1; j < n; j++) s += 64'(qmul(cells[i*n+j], inv[j*n+c]));
         inv[i*n+c] = qdiv(clip(64'(inv[i*n+c]) - s), cells[i*n+i]);
      end
   endfunction

   function void queue_result(logic signed [31:0] v, logic s, logic l);
      want_value    = {want_value, v};
      want_singular = {want_singular, s};
      want_last     = {want_last, l};
   endfunction

   function void note_element(logic signed [31:0] e);
      int n, total;
      n     = order_now();
      total = n * n;
      if (loaded >= total) loaded = 0;
      cells[loaded] = e;
      loaded++;
      if (loaded < total) return;
      loaded = 0;
      if (!factor(n)) begin
         queue_result(0, 1'b1, 1'b1);
         return;
      end
      for (int c = 0; c < n; c++) solve_column(n, c);
      for (int i = 0; i < total; i++) queue_result(inv[i], 1'b0, i == total - 1);
   endfunction

   function void check_result(logic signed [31:0] v, logic s, logic l);
      logic signed [31:0] ev;
      logic es, el;
      if (want_value.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: value %h singular %b last %b", v, s, l);
         return;
      end
      ev = want_value.pop_front();
      es = want_singular.pop_front();
      el = want_last.pop_front();
      if (v !== ev || s !== es || l !== el) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", ev, es, el, v, s, l);
      end
   endfunction

   function int pending();
      return want_value.size();
   endfunction
endclass

module tb_lu_matrix_inverse;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic signed [31:0] req_element = 0;
   logic               csr_valid = 0;
   logic [lumi_pkg::CSR_ADDR_BITS-1:0] csr_index = 0;
   logic [31:0]        csr_data = 0;
   wire                busy, csr_ready, rsp_valid, rsp_singular, rsp_last;
   wire signed [31:0]  rsp_inverse_value;

   inverse_scoreboard  board;
   int                 idle_cycles;
   bit                 no_gaps;

   lu_matrix_inverse dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_element(req_element), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .rsp_valid(rsp_valid),
      .rsp_inverse_value(rsp_inverse_value), .rsp_singular(rsp_singular),
      .rsp_last(rsp_last)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_inverse_value, rsp_singular, rsp_last);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("lu_matrix_inverse regression: fail");
            $finish;
         end
      end
   end

   // drop start for the length of a gap
   task automatic maybe_gap();
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // start stays high so that elements can follow back to back
   task automatic send_element(logic signed [31:0] e);
      maybe_gap();
      start       <= 1'b1;
      req_element <= e;
      do @(posedge clock); while (busy);
      board.note_element(e);
   endtask

   // hold until every expected result has come, then let the solver settle
   task automatic drain();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic [lumi_pkg::CSR_ADDR_BITS-1:0] idx, logic [31:0] data);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_element(int mode);
      case (mode)
         0: return $signed($urandom());
         1: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
         default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      endcase
   endfunction

   // outside mode zero each diagonal element is pushed away from zero, to keep pivots clear of the threshold
   task automatic send_matrix(int n, int mode);
      logic signed [31:0] e;
      for (int i = 0; i < n * n; i++) begin
         e = rand_element(mode);
         if (mode != 0 && i / n == i % n) e = e + (e < 0 ? -32'sh00040000 : 32'sh00040000);
         send_element(e);
      end
   endtask

   task automatic send_scaled_identity(int n, logic signed [31:0] d);
      for (int i = 0; i < n * n; i++) send_element(i / n == i % n ? d : 0);
   endtask

   initial begin
      int items;
      int n;
      board = new();
      board.clear();
      idle_cycles = 0;
      no_gaps = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size zero acts as one; extreme single elements
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 0);
      write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, 0);
      send_element(32'sh7fffffff);
      send_element(32'sh80000000);
      send_element(0);
      send_element(32'sh00010000);
      drain();
      write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, 16'hffff);
      send_element(32'sh0000fffe);
      send_element(32'shffff0001);
      send_element(32'sh00010000);
      drain();
      // oversized order falls back to eight; default threshold
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 15);
      write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, 1);
      send_scaled_identity(8, 32'sh00020000);
      drain();
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 2);
      send_element(32'sh00010000);
      send_element(32'sh00010000);
      send_element(32'sh00010000);
      send_element(32'sh00010000);
      // size write mid-load discards partial matrix
      send_element(32'sh00030000);
      drain();
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 2);
      send_matrix(2, 1);
      drain();
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 1);
      send_element(32'sh80000000);
      drain();
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 8);
      write_csr(lumi_pkg::REG_MATRIX_SIZE, 16'hfff7);

      items = 0;
      while (items < 320) begin
         if (items > 270) no_gaps = 1;
         drain();
         n = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
         write_csr(lumi_pkg::REG_MATRIX_SIZE,
                   $urandom_range(0, 5) == 0 ? 32'(n) | ($urandom() << 4) : n);
         case ($urandom_range(0, 3))
            0: write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, 0);
            1: write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, $urandom());
            default: write_csr(lumi_pkg::REG_PIVOT_THRESHOLD, $urandom_range(1, 256));
         endcase
         repeat ($urandom_range(1, 3)) begin
            send_matrix(n, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 2));
            items += n * n;
         end
      end

      drain();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("lu_matrix_inverse regression: pass");
      else
         $display("lu_matrix_inverse regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
